>>> hdl/linear_to_cineon_log_pack_macros.svh
// ----------------------------------------------------------------------------
// linear_to_cineon_log_pack assertion macros
// shared property wrappers for the cineon log packer; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LINEAR_TO_CINEON_LOG_PACK_MACROS_SVH
`define LINEAR_TO_CINEON_LOG_PACK_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while in reset
`define LCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcl assertion failed");

// next-cycle implication
`define LCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcl assertion failed");

`else

`define LCL_ASSERT_IMP(lbl, ante, cons)
`define LCL_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hdl/lcl_pkg.sv
// ----------------------------------------------------------------------------
// lcl_pkg
// constants, types and helpers for the linear to cineon log packer
// ----------------------------------------------------------------------------
package lcl_pkg;

  localparam int LIN_W   = 16;
  localparam int CODE_W  = 10;
  localparam int WORD_W  = 32;
  localparam int Y_W     = 29;  // x * 2^12 + offset, Q5.24
  localparam int P_W     = 5;   // leading one position
  localparam int M_W     = 31;  // mantissa, Q1.30
  localparam int E_W     = 6;   // signed exponent p - 24
  localparam int FRAC_W  = 16;  // log2 fraction bits
  localparam int LG_W    = E_W + FRAC_W;
  localparam int SLOPE_W = 24;
  localparam int PROD_W  = LG_W + SLOPE_W;
  localparam int ACC_W   = 48;

  // pipeline: y, lead-one, normalize, FRAC_W squarings, multiply, round/saturate
  localparam int SQ_STG   = FRAC_W;
  localparam int NUM_STG  = 3 + SQ_STG + 2;
  localparam int STG_PROD = 3 + SQ_STG;
  localparam int STG_CODE = STG_PROD + 1;

  localparam logic [Y_W-1:0]           OFFSET_Q24 = 29'd88513;
  localparam logic signed [SLOPE_W-1:0] SLOPE_Q16 = 24'sd5918491;
  localparam logic signed [ACC_W-1:0]  ACC_BASE   =
    (48'sd44781695 <<< 16) + (48'sd1 <<< 31);
  localparam logic [CODE_W-1:0]        CODE_MAX   = 10'd1023;
  localparam logic signed [E_W-1:0]    EXP_BIAS   = 6'sd24;

  typedef struct packed {
    logic [NUM_STG-1:0] adv;       // per stage load enable
    logic               out_load;  // output register load
  } lcl_adv_t;

  // position of the leading one
  function automatic logic [P_W-1:0] lead_one(input logic [Y_W-1:0] y);
    logic [P_W-1:0] p;
    p = '0;
    for (int i = 0; i < Y_W; i++) begin
      if (y[i]) p = P_W'(i);
    end
    return p;
  endfunction

endpackage

>>> hdl/lcl_lane.sv
// ----------------------------------------------------------------------------
// lcl_lane
// one channel: linear U4.12 value to 10-bit cineon log code, fully pipelined
// ----------------------------------------------------------------------------
module lcl_lane (
  input  logic                        clk,
  input  lcl_pkg::lcl_adv_t           adv,
  input  logic [lcl_pkg::LIN_W-1:0]   lin,
  output logic [lcl_pkg::CODE_W-1:0]  code
);
  import lcl_pkg::*;

  logic [Y_W-1:0]              y0_r, y1_r;
  logic [P_W-1:0]              p_r;
  logic [M_W-1:0]              m_r    [0:SQ_STG];
  logic [FRAC_W-1:0]           frac_r [0:SQ_STG];
  logic signed [E_W-1:0]       e_r    [0:SQ_STG];
  logic signed [PROD_W-1:0]    prod_r;
  logic [CODE_W-1:0]           code_r;

  logic signed [LG_W-1:0]      lg;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [ACC_W-1:0]     acc;
  logic [CODE_W-1:0]           code_nxt;

  // offset add, then leading one, then normalize
  always_ff @(posedge clk) begin
    if (adv.adv[0]) y0_r <= {{(Y_W-LIN_W-12){1'b0}}, lin, 12'd0} + OFFSET_Q24;
    if (adv.adv[1]) begin
      y1_r <= y0_r;
      p_r  <= lead_one(y0_r);
    end
    if (adv.adv[2]) begin
      m_r[0]    <= M_W'({{(M_W-Y_W){1'b0}}, y1_r} << (P_W'(M_W - 1) - p_r));
      e_r[0]    <= $signed({1'b0, p_r}) - EXP_BIAS;
      frac_r[0] <= '0;
    end
  end

  // one squaring per stage, one fraction bit each
  for (genvar k = 0; k < SQ_STG; k++) begin : g_sq
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     t;
    assign sq = {{M_W{1'b0}}, m_r[k]} * {{M_W{1'b0}}, m_r[k]};
    assign t  = sq[2*M_W-1:M_W-1];
    always_ff @(posedge clk) begin
      if (adv.adv[3+k]) begin
        m_r[k+1]    <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
        frac_r[k+1] <= {frac_r[k][FRAC_W-2:0], t[M_W]};
        e_r[k+1]    <= e_r[k];
      end
    end
  end

  assign lg       = {e_r[SQ_STG], frac_r[SQ_STG]};
  assign prod_nxt = lg * SLOPE_Q16;
  assign acc      = ACC_W'(prod_r) + ACC_BASE;

  // round is folded into ACC_BASE; clamp to 0..1023
  always_comb begin
    if (acc[ACC_W-1])                    code_nxt = '0;
    else if (|acc[ACC_W-2:32+CODE_W])    code_nxt = CODE_MAX;
    else                                 code_nxt = acc[32+CODE_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (adv.adv[STG_PROD]) prod_r <= prod_nxt;
    if (adv.adv[STG_CODE]) code_r <= code_nxt;
  end

  assign code = code_r;

endmodule

>>> hdl/lcl_ctrl.sv
// ----------------------------------------------------------------------------
// lcl_ctrl
// valid tracking and bubble-collapsing advance chain for the lane pipeline
// ----------------------------------------------------------------------------
`include "linear_to_cineon_log_pack_macros.svh"

module lcl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lcl_pkg::lcl_adv_t adv
);
  import lcl_pkg::*;

  logic [NUM_STG-1:0] vld_r, vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [NUM_STG:0]   rdy;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    rdy[NUM_STG] = !out_vld_r || !out_stall;
    for (int i = NUM_STG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt     = vld_r;
    out_vld_nxt = out_vld_r;
    if (rdy[0]) vld_nxt[0] = in_valid;
    for (int i = 1; i < NUM_STG; i++) begin
      if (rdy[i]) vld_nxt[i] = vld_r[i-1];
    end
    if (rdy[NUM_STG]) out_vld_nxt = vld_r[NUM_STG-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign adv.adv      = rdy[NUM_STG-1:0];
  assign adv.out_load = rdy[NUM_STG];
  assign in_stall     = !rdy[0];
  assign out_valid    = out_vld_r;

  `LCL_ASSERT_NXT(a_accept_fills, in_valid && !in_stall, vld_r[0])
  `LCL_ASSERT_IMP(a_stall_only_full, in_stall, (&vld_r) && out_vld_r && out_stall)
  `LCL_ASSERT_NXT(a_drain_empties, out_vld_r && !out_stall && !vld_r[NUM_STG-1], !out_vld_r)
  `LCL_ASSERT_NXT(a_last_moves_out, vld_r[NUM_STG-1] && !out_vld_r, out_vld_r)

endmodule

>>> hdl/lcl_merge.sv
// ----------------------------------------------------------------------------
// lcl_merge
// packs the three lane codes into the output word register
// ----------------------------------------------------------------------------
module lcl_merge (
  input  logic                        clk,
  input  lcl_pkg::lcl_adv_t           adv,
  input  logic [lcl_pkg::CODE_W-1:0]  code_red,
  input  logic [lcl_pkg::CODE_W-1:0]  code_green,
  input  logic [lcl_pkg::CODE_W-1:0]  code_blue,
  output logic [lcl_pkg::WORD_W-1:0]  word
);
  import lcl_pkg::*;

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (adv.out_load) word_r <= {code_red, code_green, code_blue, 2'b00};
  end

  assign word = word_r;

endmodule

>>> hdl/linear_to_cineon_log_pack.sv
// ----------------------------------------------------------------------------
// linear_to_cineon_log_pack
// linear RGB (U4.12) to packed 10-bit cineon printing-density log codes
// ----------------------------------------------------------------------------
// an accepted request passes all pipeline stages and the output register
// throughput: one pixel per clock when not stalled; the 16 squaring stages
// of each lane are fully pipelined, one 31x31 multiply per stage
// in_stall rises only when every pipeline stage and the output register hold
// data and out_stall is high; empty stages collapse so requests keep flowing
// reset: synchronous active-low rst_n clears all valid flags, data regs keep
// ----------------------------------------------------------------------------
module linear_to_cineon_log_pack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lcl_pkg::LIN_W-1:0]   in_lin_red,
  input  logic [lcl_pkg::LIN_W-1:0]   in_lin_green,
  input  logic [lcl_pkg::LIN_W-1:0]   in_lin_blue,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lcl_pkg::WORD_W-1:0]  out_packed_word
);
  import lcl_pkg::*;

  lcl_adv_t          adv;
  logic [CODE_W-1:0] code_red, code_green, code_blue;

  // handshake and per-stage load enables shared by all three lanes
  lcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .adv       (adv)
  );

  // one lane per color channel, running in lockstep:
  // offset add, leading one, normalize, log2 by squaring, scale, round, clamp
  lcl_lane u_lane_red (
    .clk  (clk),
    .adv  (adv),
    .lin  (in_lin_red),
    .code (code_red)
  );

  lcl_lane u_lane_green (
    .clk  (clk),
    .adv  (adv),
    .lin  (in_lin_green),
    .code (code_green)
  );

  lcl_lane u_lane_blue (
    .clk  (clk),
    .adv  (adv),
    .lin  (in_lin_blue),
    .code (code_blue)
  );

  // red 31:22, green 21:12, blue 11:2, low two bits zero
  lcl_merge u_merge (
    .clk        (clk),
    .adv        (adv),
    .code_red   (code_red),
    .code_green (code_green),
    .code_blue  (code_blue),
    .word       (out_packed_word)
  );

endmodule
